// File: rtl/core/fdec_pkg.sv
package fdec_pkg;

    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [4:0] MAX_LONG_RECORDS = 5'd20;

    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_DAT_W-1:0] t_cfg_dat;

    localparam t_status ST_SHORT_OK = 4'd0;
    localparam t_status ST_LONG_OK  = 4'd1;
    localparam t_status ST_DELETED  = 4'd2;
    localparam t_status ST_LABEL    = 4'd3;
    localparam t_status ST_DOT_OK   = 4'd4;
    localparam t_status ST_END      = 4'd5;
    localparam t_status ST_STOPPED  = 4'd6;
    localparam t_status ST_ORPHAN   = 4'd7;
    localparam t_status ST_LONG_BAD = 4'd8;
    localparam t_status ST_MISMATCH = 4'd9;
    localparam t_status ST_HIGH     = 4'd10;
    localparam t_status ST_DOT_BAD  = 4'd11;

    localparam t_cfg_idx CFG_DIR_IS_ROOT  = 2'd0;
    localparam t_cfg_idx CFG_SELF_CLUSTER = 2'd1;
    localparam t_cfg_idx CFG_PARENT_CLUSTER = 2'd2;

    localparam logic [7:0]  BYTE_END     = 8'h00;
    localparam logic [7:0]  BYTE_DELETED = 8'he5;
    localparam logic [7:0]  ATTR_LONG    = 8'h0f;
    localparam logic [7:0]  ATTR_VOL_DIR = 8'h18;
    localparam logic [7:0]  ATTR_DIR     = 8'h10;
    localparam int          ATTR_VOL_BIT = 3;
    localparam int          LONG_FIRST_BIT = 6;

    localparam logic [63:0] NAME_DOT    = 64'h2020_2020_2020_202e;
    localparam logic [63:0] NAME_DOTDOT = 64'h2020_2020_2020_2e2e;
    localparam logic [23:0] EXT_BLANK   = 24'h20_2020;

endpackage

// File: rtl/core/fdec_in_if.sv
interface fdec_in_if;
    logic        valid;
    logic        ready;
    logic        start_of_directory;
    logic        end_of_directory;
    logic [63:0] name_bytes;
    logic [23:0] ext_bytes;
    logic [7:0]  attributes;
    logic [7:0]  reserved_byte;
    logic [7:0]  long_checksum;
    logic [15:0] high_cluster;
    logic [15:0] first_cluster;
    logic [31:0] file_size;

    modport source (
        output valid, start_of_directory, end_of_directory, name_bytes, ext_bytes,
               attributes, reserved_byte, long_checksum, high_cluster, first_cluster,
               file_size,
        input  ready
    );
    modport sink (
        input  valid, start_of_directory, end_of_directory, name_bytes, ext_bytes,
               attributes, reserved_byte, long_checksum, high_cluster, first_cluster,
               file_size,
        output ready
    );
endinterface

// File: rtl/core/fdec_out_if.sv
interface fdec_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [4:0] attached_long_count;

    modport source (output valid, status, attached_long_count, input ready);
    modport sink (input valid, status, attached_long_count, output ready);
endinterface

// File: rtl/core/fdec_cfg_if.sv
interface fdec_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/core/fdec_name_sum.sv
module fdec_name_sum #(
    parameter int NBYTES = 6
) (
    input  logic [7:0]          i_seed,
    input  logic [8*NBYTES-1:0] i_bytes,
    output logic [7:0]          o_sum
);
    logic [7:0] acc;

    // rotate right by one, then add the next name byte
    always_comb begin
        acc = i_seed;
        for (int i = 0; i < NBYTES; i++) begin
            acc = {acc[0], acc[7:1]} + i_bytes[8*i +: 8];
        end
        o_sum = acc;
    end
endmodule

// File: rtl/core/fat_directory_entry_checker_core.sv
// Channel   Port       Dir   Word
// entry     i_entry    in    one 32-byte directory entry, split into fields
// verdict   o_verdict  out   status and attached long-record count
// config    i_cfg      in    register index and write data, always ready
//
// One entry per cycle while o_verdict is ready; the verdict is registered in stage 2.
// Stage 1 registers the entry with the dot-name flags and the checksum over bytes 0-5;
// stage 2 finishes the checksum over bytes 6-10 and updates the run state.
// Active-low sync reset clears run state, stop, valid and cluster regs; sets dir-is-root.
// A stalled output holds its word; an empty stage still accepts a new entry.
module fat_directory_entry_checker_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fdec_in_if.sink    i_entry,
    fdec_out_if.source o_verdict,
    fdec_cfg_if.sink   i_cfg
);
    import fdec_pkg::*;

    logic        r_dir_is_root;
    logic [15:0] r_self_cluster;
    logic [15:0] r_parent_cluster;

    logic [4:0]  r_ordl;
    logic [7:0]  r_sum;
    logic [4:0]  r_pend;
    logic        r_stopped;
    logic [4:0]  n_ordl;
    logic [7:0]  n_sum;
    logic [4:0]  n_pend;
    logic        n_stopped;

    logic        r_s1_vld;
    logic        r_s1_start;
    logic        r_s1_end;
    logic [7:0]  r_s1_first;
    logic [39:0] r_s1_tail;
    logic [7:0]  r_s1_psum;
    logic        r_s1_dot1;
    logic        r_s1_dot2;
    logic [7:0]  r_s1_attr;
    logic        r_s1_resv_nz;
    logic [7:0]  r_s1_lsum;
    logic        r_s1_hic_nz;
    logic [15:0] r_s1_fclu;
    logic        r_s1_fsize_nz;

    logic        r_out_vld;
    t_status     r_status;
    t_count      r_count;
    t_status     n_status;
    t_count      n_count;

    logic        s1_adv;
    logic        s2_adv;
    logic        s2_fire;
    logic [7:0]  in_psum;
    logic [7:0]  full_sum;

    logic        cur_stop;
    logic [4:0]  cur_ordl;
    logic [7:0]  cur_sum;
    logic [4:0]  cur_pend;
    logic [4:0]  ord;
    logic        pend_nz;
    logic [4:0]  eff_ordl;
    logic [7:0]  eff_sum;
    logic        long_bad;
    logic        mismatch;
    logic [15:0] dot_expect;

    fdec_name_sum #(.NBYTES(6)) u_sum_head (
        .i_seed  (8'h00),
        .i_bytes (i_entry.name_bytes[47:0]),
        .o_sum   (in_psum)
    );

    fdec_name_sum #(.NBYTES(5)) u_sum_tail (
        .i_seed  (r_s1_psum),
        .i_bytes (r_s1_tail),
        .o_sum   (full_sum)
    );

    assign s2_adv  = !r_out_vld || o_verdict.ready;
    assign s1_adv  = !r_s1_vld || s2_adv;
    assign s2_fire = r_s1_vld && s2_adv;

    assign i_entry.ready = s1_adv;
    assign i_cfg.ready   = 1'b1;

    assign o_verdict.valid               = r_out_vld;
    assign o_verdict.status              = r_status;
    assign o_verdict.attached_long_count = r_count;

    always_comb begin
        cur_stop   = r_s1_start ? 1'b0  : r_stopped;
        cur_ordl   = r_s1_start ? 5'd0  : r_ordl;
        cur_sum    = r_s1_start ? 8'h00 : r_sum;
        cur_pend   = r_s1_start ? 5'd0  : r_pend;
        pend_nz    = (cur_pend != 5'd0);
        ord        = r_s1_first[4:0];
        eff_ordl   = pend_nz ? cur_ordl : ord;
        eff_sum    = pend_nz ? cur_sum : r_s1_lsum;
        long_bad   = (ord == 5'd0) || (ord > MAX_LONG_RECORDS) || (ord != eff_ordl) ||
                     (r_s1_first != {1'b0, !pend_nz, 1'b0, ord}) || r_s1_resv_nz ||
                     (r_s1_fclu != 16'h0000) || (r_s1_lsum != eff_sum);
        mismatch   = pend_nz && ((cur_ordl != 5'd0) || (full_sum != cur_sum) ||
                     r_s1_attr[ATTR_VOL_BIT] || r_s1_dot1 || r_s1_dot2);
        dot_expect = r_s1_dot2 ? r_parent_cluster : r_self_cluster;

        n_ordl    = cur_ordl;
        n_sum     = cur_sum;
        n_pend    = cur_pend;
        n_stopped = cur_stop;
        n_count   = '0;
        n_status  = ST_SHORT_OK;

        if (cur_stop) begin
            n_status = ST_STOPPED;
        end else if (r_s1_first == BYTE_END) begin
            n_status = pend_nz ? ST_ORPHAN : ST_END;
        end else if (r_s1_first == BYTE_DELETED) begin
            n_status = pend_nz ? ST_ORPHAN : ST_DELETED;
        end else if (r_s1_attr == ATTR_LONG) begin
            n_ordl = eff_ordl;
            n_sum  = eff_sum;
            if (long_bad) begin
                n_status = ST_LONG_BAD;
            end else begin
                n_ordl   = eff_ordl - 5'd1;
                n_pend   = cur_pend + 5'd1;
                n_status = r_s1_end ? ST_ORPHAN : ST_LONG_OK;
            end
        end else if (mismatch) begin
            n_status = ST_MISMATCH;
        end else if (r_s1_hic_nz) begin
            n_status = ST_HIGH;
        end else if (r_s1_dot1 || r_s1_dot2) begin
            if (r_dir_is_root || ((r_s1_attr & ATTR_VOL_DIR) != ATTR_DIR) ||
                r_s1_fsize_nz || (r_s1_fclu != dot_expect)) begin
                n_status = ST_DOT_BAD;
            end else begin
                n_status = ST_DOT_OK;
            end
        end else if (r_s1_attr[ATTR_VOL_BIT]) begin
            n_status = ST_LABEL;
        end else begin
            n_status = ST_SHORT_OK;
            n_count  = cur_pend;
            n_ordl   = 5'd0;
            n_sum    = 8'h00;
            n_pend   = 5'd0;
        end

        if (!cur_stop && (n_status >= ST_ORPHAN || n_status == ST_END)) begin
            n_stopped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_is_root    <= 1'b1;
            r_self_cluster   <= '0;
            r_parent_cluster <= '0;
            r_ordl           <= '0;
            r_sum            <= '0;
            r_pend           <= '0;
            r_stopped        <= 1'b0;
            r_s1_vld         <= 1'b0;
            r_out_vld        <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.reg_index)
                    CFG_DIR_IS_ROOT:    r_dir_is_root    <= i_cfg.wdata[0];
                    CFG_SELF_CLUSTER:   r_self_cluster   <= i_cfg.wdata;
                    CFG_PARENT_CLUSTER: r_parent_cluster <= i_cfg.wdata;
                    default: ;
                endcase
            end
            if (s1_adv) begin
                r_s1_vld <= i_entry.valid;
            end
            if (s2_adv) begin
                r_out_vld <= r_s1_vld;
            end
            if (s2_fire) begin
                r_ordl    <= n_ordl;
                r_sum     <= n_sum;
                r_pend    <= n_pend;
                r_stopped <= n_stopped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_entry.valid) begin
            r_s1_start    <= i_entry.start_of_directory;
            r_s1_end      <= i_entry.end_of_directory;
            r_s1_first    <= i_entry.name_bytes[7:0];
            r_s1_tail     <= {i_entry.ext_bytes, i_entry.name_bytes[63:48]};
            r_s1_psum     <= in_psum;
            r_s1_dot1     <= (i_entry.name_bytes == NAME_DOT) &&
                             (i_entry.ext_bytes == EXT_BLANK);
            r_s1_dot2     <= (i_entry.name_bytes == NAME_DOTDOT) &&
                             (i_entry.ext_bytes == EXT_BLANK);
            r_s1_attr     <= i_entry.attributes;
            r_s1_resv_nz  <= (i_entry.reserved_byte != 8'h00);
            r_s1_lsum     <= i_entry.long_checksum;
            r_s1_hic_nz   <= (i_entry.high_cluster != 16'h0000);
            r_s1_fclu     <= i_entry.first_cluster;
            r_s1_fsize_nz <= (i_entry.file_size != 32'h0000_0000);
        end
        if (s2_fire) begin
            r_status <= n_status;
            r_count  <= n_count;
        end
    end

    a_count_only_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_count != 5'd0)) |-> (r_status == ST_SHORT_OK))
        else $error("long count on a verdict other than short ok");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend <= MAX_LONG_RECORDS))
        else $error("pending long records exceed limit");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pend != 5'd0) && !r_stopped) |->
        (({1'b0, r_pend} + {1'b0, r_ordl}) <= {1'b0, MAX_LONG_RECORDS}))
        else $error("run ordinals inconsistent with pending count");

    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && (n_status >= ST_ORPHAN)) |=> r_stopped)
        else $error("error verdict did not stop the checker");

endmodule
